// File: rtl/core/bmh_pkg.sv
// Shared types, codes and defaults for the binary min-heap engine.
package bmh_pkg;

	// Default sizing of the heap store and key width.
	localparam int CAPACITY_DEF  = 255;
	localparam int KEY_WIDTH_DEF = 32;

	// Operation codes carried in the request beat.
	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_DECREASE = 2'd1;
	localparam logic [1:0] OP_INCREASE = 2'd2;
	localparam logic [1:0] OP_READ     = 2'd3;

	// Status codes returned in the response beat.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_SMALLER = 3'd1;
	localparam logic [2:0] ST_NOT_LARGER  = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX   = 3'd4;

	// Request beat.
	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         index;
		logic signed [31:0] key;
	} req_beat_t;

	// Response beat.
	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         count;
		logic signed [31:0] min_key;
		logic signed [31:0] read_value;
	} rsp_beat_t;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISPATCH = 8'b0000_0010,
		S_CHECK    = 8'b0000_0100,
		S_UP_RD    = 8'b0000_1000,
		S_UP_CMP   = 8'b0001_0000,
		S_DN_RD    = 8'b0010_0000,
		S_DN_CMP   = 8'b0100_0000,
		S_FINISH   = 8'b1000_0000
	} state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic       capture;
		logic       insert;
		logic       rd_pos;
		logic       rd_parent;
		logic       rd_children;
		logic       wr_key;
		logic       wr_up;
		logic       wr_dn;
		logic       set_status;
		logic [2:0] status;
		logic       latch_readv;
		logic       load_out;
	} dp_cmd_t;

	// Flags from the datapath to the sequencer.
	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       bad_index;
		logic       key_lt_data;
		logic       data_lt_key;
		logic       at_root;
		logic       no_left;
		logic       child_lt_key;
	} dp_flags_t;

endpackage

// File: rtl/core/binary_min_heap_engine.sv
// Binary min-heap engine: insert, decrease-key, increase-key and read on a keyed store.
//
// Usage: one request beat (req, req_valid/req_stall) carries an operation, a
// one-based index and a signed key. Each request yields exactly one response
// beat (rsp, rsp_valid/rsp_stall) with a status, the entry count, the root
// key (zero when empty) and, for reads, the key at the index.
// A full heap or a bad index is answered straight from dispatch, a read or a
// refused key after the check state, and a sift after moving the key level by level.
// One request is in flight at a time: the sift loop owns the key store's single
// write port, so req_stall is high from acceptance until the response is loaded,
// and the next request is taken once the sequencer is back in idle.
// A response waiting under rsp_stall sits in an output register; the next
// request is accepted meanwhile and is held in its last cycle until the
// register is taken.
// Reset clears the entry count and both handshakes; the key store is not
// cleared, since only live entries are ever read.
module binary_min_heap_engine
	import bmh_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	dp_cmd_t   cmd;
	dp_flags_t flags;

	// Sequencer.
	bmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	// Datapath with the key store.
	bmh_datapath #(
		.CAPACITY (CAPACITY),
		.KEY_WIDTH(KEY_WIDTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.flags (flags),
		.rsp   (rsp)
	);

endmodule

// File: rtl/core/bmh_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and two registered reads per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: rtl/core/bmh_datapath.sv
// Heap datapath: item registers, sift position, comparators and the key store.
module bmh_datapath
	import bmh_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req,
	input  dp_cmd_t   cmd,
	output dp_flags_t flags,
	output rsp_beat_t rsp
);

	localparam int AW = $clog2(CAPACITY + 1);
	localparam int IW = (AW > 8) ? AW : 8;

	logic [AW-1:0]               cnt_q;
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               left_q;
	logic                        rvalid_q;
	logic [1:0]                  op_q;
	logic [7:0]                  idx_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic signed [KEY_WIDTH-1:0] root_q;
	logic signed [KEY_WIDTH-1:0] readv_q;
	logic [2:0]                  status_q;
	rsp_beat_t                   rsp_q;

	logic [KEY_WIDTH-1:0]        rd_a;
	logic [KEY_WIDTH-1:0]        rd_b;
	logic signed [KEY_WIDTH-1:0] rd_a_s;
	logic signed [KEY_WIDTH-1:0] rd_b_s;
	logic [AW:0]                 left;
	logic [AW:0]                 right;
	logic                        sel_right;
	logic signed [KEY_WIDTH-1:0] child_val;
	logic [AW-1:0]               child_pos;
	logic                        we;
	logic [KEY_WIDTH-1:0]        wdata;
	logic [AW-1:0]               raddr_a;

	assign rd_a_s = $signed(rd_a);
	assign rd_b_s = $signed(rd_b);

	// Children of the current position, one bit wider so the limit test is exact.
	assign left  = {pos_q, 1'b0};
	assign right = left + (AW + 1)'(1);

	// Smaller of the two children; the right one only counts when it is live.
	assign sel_right = rvalid_q && (rd_b_s < rd_a_s);
	assign child_val = sel_right ? rd_b_s : rd_a_s;
	assign child_pos = {left_q[AW-1:1], sel_right};

	// Store addressing and write data.
	always_comb begin
		if (cmd.rd_parent) begin
			raddr_a = pos_q >> 1;
		end else if (cmd.rd_children) begin
			raddr_a = left[AW-1:0];
		end else begin
			raddr_a = pos_q;
		end
	end

	assign we = cmd.wr_key | cmd.wr_up | cmd.wr_dn;

	always_comb begin
		if (cmd.wr_up) begin
			wdata = rd_a;
		end else if (cmd.wr_dn) begin
			wdata = child_val;
		end else begin
			wdata = key_q;
		end
	end

	bmh_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(CAPACITY + 1)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (pos_q),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(right[AW-1:0]),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// Flags for the sequencer.
	always_comb begin
		flags.op           = op_q;
		flags.full         = (cnt_q == AW'(CAPACITY));
		flags.bad_index    = (idx_q == 8'd0) || (IW'(idx_q) > IW'(cnt_q));
		flags.key_lt_data  = key_q < rd_a_s;
		flags.data_lt_key  = rd_a_s < key_q;
		flags.at_root      = (pos_q == AW'(1));
		flags.no_left      = left > (AW + 1)'(cnt_q);
		flags.child_lt_key = child_val < key_q;
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.insert) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Item registers, sift position and the mirrored root key.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req.op;
			idx_q    <= req.index;
			pos_q    <= AW'(req.index);
			key_q    <= KEY_WIDTH'(req.key);
			status_q <= ST_OK;
			readv_q  <= '0;
		end
		if (cmd.insert) begin
			pos_q <= cnt_q + AW'(1);
		end
		if (cmd.wr_up) begin
			pos_q <= pos_q >> 1;
		end
		if (cmd.wr_dn) begin
			pos_q <= child_pos;
		end
		if (cmd.rd_children) begin
			left_q   <= left[AW-1:0];
			rvalid_q <= right <= (AW + 1)'(cnt_q);
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.latch_readv) begin
			readv_q <= rd_a_s;
		end
		if (we && (pos_q == AW'(1))) begin
			root_q <= $signed(wdata);
		end
		if (cmd.load_out) begin
			rsp_q.status     <= status_q;
			rsp_q.count      <= 8'(cnt_q);
			rsp_q.min_key    <= (cnt_q == '0) ? 32'sd0 : 32'(root_q);
			rsp_q.read_value <= 32'(readv_q);
		end
	end

	assign rsp = rsp_q;

`ifndef ASSERT_OFF
	// The entry count never passes the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= AW'(CAPACITY))
		else $error("entry count above capacity");

	// Every store write lands inside the live region.
	a_wr_live: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (pos_q != '0) && (pos_q <= cnt_q))
		else $error("store write outside live entries");

	// An upward move never starts from the root.
	a_up_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_up |-> (pos_q > AW'(1)))
		else $error("upward move at root");
`endif

endmodule

// File: rtl/core/bmh_ctrl.sv
// Heap sequencer: accepts request beats, steps the sift and issues response beats.
module bmh_ctrl
	import bmh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (flags.op == OP_INSERT) begin
					if (flags.full) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_FULL;
						state_d        = S_FINISH;
					end else begin
						cmd.insert = 1'b1;
						state_d    = S_UP_RD;
					end
				end else if (flags.bad_index) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_BAD_INDEX;
					state_d        = S_FINISH;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				case (flags.op)
					OP_DECREASE: begin
						if (flags.key_lt_data) begin
							state_d = S_UP_RD;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NOT_SMALLER;
							state_d        = S_FINISH;
						end
					end
					OP_INCREASE: begin
						if (flags.data_lt_key) begin
							state_d = S_DN_RD;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NOT_LARGER;
							state_d        = S_FINISH;
						end
					end
					default: begin
						cmd.latch_readv = 1'b1;
						state_d         = S_FINISH;
					end
				endcase
			end
			S_UP_RD: begin
				if (flags.at_root) begin
					cmd.wr_key = 1'b1;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (flags.key_lt_data) begin
					cmd.wr_up = 1'b1;
					state_d   = S_UP_RD;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = S_FINISH;
				end
			end
			S_DN_RD: begin
				if (flags.no_left) begin
					cmd.wr_key = 1'b1;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_children = 1'b1;
					state_d         = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (flags.child_lt_key) begin
					cmd.wr_dn = 1'b1;
					state_d   = S_DN_RD;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// An accepted request beat always moves the sequencer to dispatch.
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted beat did not reach dispatch");
`endif

endmodule
